// ===== hw/rtl/convex_hull_2d_defines.svh =====
// assertion helpers used by the checker file
`ifndef CONVEX_HULL_2D_DEFINES_SVH
`define CONVEX_HULL_2D_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CHX_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define CHX_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/chx_pkg.sv =====
// ----------------------------------------------------------------------------
// chx_pkg
// shared constants for the convex hull block
// ----------------------------------------------------------------------------
`default_nettype none

package chx_pkg;
  localparam int MAX_POINTS_DEF  = 64;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int IO_W            = 32;
  localparam int HULL_SIZE_W     = 7;
  localparam int SMALL_SET_MAX   = 3;
  localparam int CHAIN_MIN       = 2;
endpackage

`default_nettype wire

// ===== hw/rtl/chx_ram.sv =====
// ----------------------------------------------------------------------------
// chx_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module chx_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

`default_nettype wire

// ===== hw/rtl/convex_hull_2d.sv =====
// ----------------------------------------------------------------------------
// convex_hull_2d
// monotone chain convex hull over a loaded point set
// ----------------------------------------------------------------------------
//
// channel   dir  handshake             words
// in_*      in   in_valid / in_ready    one point, last_point closes the set
// out_*     out  out_valid / out_ready  one hull vertex, final_vertex on the last
//
// loading takes one cycle per point; in_ready is high only while loading
// after the closing point: insertion sort, each point read and latched, each shift
// a read then a compare and write; each chain step reads and latches a point, each
// cross product test forms two products on the shared multiplier, a pop reloads
// the chain top, then the point is appended; each emitted vertex waits for out_ready
// reset clears the fsm and the load count; the rams need no clearing pass
`default_nettype none

module convex_hull_2d #(
  parameter int MAX_POINTS  = chx_pkg::MAX_POINTS_DEF,
  parameter int COORD_WIDTH = chx_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic signed [chx_pkg::IO_W-1:0]        in_point_x,
  input  wire logic signed [chx_pkg::IO_W-1:0]        in_point_y,
  input  wire logic                                   in_last_point,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic signed [chx_pkg::IO_W-1:0]             out_hull_x,
  output logic signed [chx_pkg::IO_W-1:0]             out_hull_y,
  output logic        [chx_pkg::HULL_SIZE_W-1:0]      out_hull_size,
  output logic                                        out_final_vertex,
  output logic                                        out_points_dropped
);
  import chx_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int DW   = CW + 1;              // coordinate difference
  localparam int PW   = 2 * DW;              // cross product term
  localparam int PTW  = 2 * CW;              // packed {y, x}
  localparam int AW   = $clog2(MAX_POINTS);
  localparam int CD   = 2 * MAX_POINTS;      // upper chain low, lower chain high
  localparam int CAW  = $clog2(CD);
  localparam int CNTW = $clog2(MAX_POINTS + 1);

  typedef enum logic [15:0] {
    ST_IDLE = 16'b0000_0000_0000_0001,
    ST_SI   = 16'b0000_0000_0000_0010,
    ST_SV   = 16'b0000_0000_0000_0100,
    ST_SJ   = 16'b0000_0000_0000_1000,
    ST_SC   = 16'b0000_0000_0001_0000,
    ST_CR   = 16'b0000_0000_0010_0000,
    ST_CP   = 16'b0000_0000_0100_0000,
    ST_CT   = 16'b0000_0000_1000_0000,
    ST_CM1  = 16'b0000_0001_0000_0000,
    ST_CM2  = 16'b0000_0010_0000_0000,
    ST_CD   = 16'b0000_0100_0000_0000,
    ST_CL   = 16'b0000_1000_0000_0000,
    ST_CU   = 16'b0001_0000_0000_0000,
    ST_ER   = 16'b0010_0000_0000_0000,
    ST_EW   = 16'b0100_0000_0000_0000,
    ST_EO   = 16'b1000_0000_0000_0000
  } state_t;

  // control
  state_t            state_r, state_nxt;
  logic [CNTW-1:0]   cnt_r, cnt_nxt;
  logic              ovf_r, ovf_nxt;
  // sequencing payload
  logic [CNTW-1:0]   n_r, n_nxt;
  logic              dropped_r, dropped_nxt;
  logic [CNTW-1:0]   i_r, i_nxt;
  logic [CNTW-1:0]   j_r, j_nxt;
  logic [CNTW-1:0]   k_r, k_nxt;
  logic [CNTW-1:0]   len_r, len_nxt;
  logic [CNTW-1:0]   nu_r, nu_nxt;
  logic [CNTW-1:0]   size_r, size_nxt;
  logic [CNTW-1:0]   e_r, e_nxt;
  logic              lower_r, lower_nxt;
  logic              small_r, small_nxt;
  logic signed [CW-1:0] vx_r, vx_nxt, vy_r, vy_nxt;
  logic signed [CW-1:0] px_r, px_nxt, py_r, py_nxt;
  logic signed [CW-1:0] t1x_r, t1x_nxt, t1y_r, t1y_nxt;
  logic signed [CW-1:0] t2x_r, t2x_nxt, t2y_r, t2y_nxt;
  logic signed [PW-1:0] prod1_r, prod1_nxt, prod2_r, prod2_nxt;
  logic signed [CW-1:0] ox_r, ox_nxt, oy_r, oy_nxt;
  logic              ofin_r, ofin_nxt;

  // ram ports
  logic              p_we, c_we;
  logic [AW-1:0]     p_waddr, p_raddr;
  logic [CAW-1:0]    c_waddr, c_raddr;
  logic [PTW-1:0]    p_wdata, p_rdata, c_wdata, c_rdata;

  chx_ram #(.WIDTH(PTW), .DEPTH(MAX_POINTS)) u_point_ram (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  chx_ram #(.WIDTH(PTW), .DEPTH(CD)) u_chain_ram (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .raddr(c_raddr), .rdata(c_rdata)
  );

  // unpacked read words
  logic signed [CW-1:0] prx, pry, crx, cry;
  assign prx = p_rdata[CW-1:0];
  assign pry = p_rdata[PTW-1:CW];
  assign crx = c_rdata[CW-1:0];
  assign cry = c_rdata[PTW-1:CW];

  // sort order: x first, then y
  logic v_less;
  assign v_less = (vx_r < prx) || ((vx_r == prx) && (vy_r < pry));

  // shared multiplier, a = t2, b = t1, c = p
  logic signed [DW-1:0] bax, bay, cax, cay, mul_a, mul_b;
  logic signed [PW-1:0] mul_p;
  logic                 drop_mid;
  assign bax = DW'(t1x_r) - DW'(t2x_r);
  assign bay = DW'(t1y_r) - DW'(t2y_r);
  assign cax = DW'(px_r) - DW'(t2x_r);
  assign cay = DW'(py_r) - DW'(t2y_r);
  assign mul_a = (state_r == ST_CM1) ? bax : bay;
  assign mul_b = (state_r == ST_CM1) ? cay : cax;
  assign mul_p = mul_a * mul_b;
  // cross product >= 0 pops the middle point
  assign drop_mid = (prod1_r >= prod2_r);

  // chain base address for the current phase
  logic [CAW-1:0] c_base;
  assign c_base = lower_r ? CAW'(MAX_POINTS) : '0;

  // emission address into the chain ram: upper run, then lower interior
  logic [CAW-1:0] e_caddr;
  assign e_caddr = (e_r < nu_r) ? CAW'(e_r)
                                : CAW'(MAX_POINTS) + CAW'(e_r) - CAW'(nu_r) + CAW'(1);

  logic in_acc;
  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    ovf_nxt     = ovf_r;
    n_nxt       = n_r;
    dropped_nxt = dropped_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    k_nxt       = k_r;
    len_nxt     = len_r;
    nu_nxt      = nu_r;
    size_nxt    = size_r;
    e_nxt       = e_r;
    lower_nxt   = lower_r;
    small_nxt   = small_r;
    vx_nxt      = vx_r;
    vy_nxt      = vy_r;
    px_nxt      = px_r;
    py_nxt      = py_r;
    t1x_nxt     = t1x_r;
    t1y_nxt     = t1y_r;
    t2x_nxt     = t2x_r;
    t2y_nxt     = t2y_r;
    prod1_nxt   = prod1_r;
    prod2_nxt   = prod2_r;
    ox_nxt      = ox_r;
    oy_nxt      = oy_r;
    ofin_nxt    = ofin_r;
    p_we        = 1'b0;
    p_waddr     = cnt_r[AW-1:0];
    p_wdata     = {in_point_y[CW-1:0], in_point_x[CW-1:0]};
    p_raddr     = i_r[AW-1:0];
    c_we        = 1'b0;
    c_waddr     = c_base + CAW'(len_r);
    c_wdata     = {py_r, px_r};
    c_raddr     = c_base + CAW'(len_r) - CAW'(3);

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          logic full;
          full = (cnt_r == CNTW'(MAX_POINTS));
          p_we = !full;
          if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            cnt_nxt = cnt_r + CNTW'(1);
          end
          if (in_last_point) begin
            n_nxt       = full ? cnt_r : cnt_r + CNTW'(1);
            dropped_nxt = ovf_r || full;
            cnt_nxt     = '0;
            ovf_nxt     = 1'b0;
            i_nxt       = CNTW'(1);
            state_nxt   = ST_SI;
          end
        end
      end
      // insertion sort over the point ram
      ST_SI: begin
        p_raddr = i_r[AW-1:0];
        if (i_r >= n_r) begin
          e_nxt = '0;
          if (n_r <= CNTW'(SMALL_SET_MAX)) begin
            small_nxt = 1'b1;
            size_nxt  = n_r;
            state_nxt = ST_ER;
          end else begin
            small_nxt = 1'b0;
            lower_nxt = 1'b0;
            len_nxt   = '0;
            k_nxt     = '0;
            state_nxt = ST_CR;
          end
        end else begin
          state_nxt = ST_SV;
        end
      end
      ST_SV: begin
        vx_nxt    = prx;
        vy_nxt    = pry;
        j_nxt     = i_r;
        state_nxt = ST_SJ;
      end
      ST_SJ: begin
        p_raddr = AW'(j_r - CNTW'(1));
        if (j_r == '0) begin
          p_we      = 1'b1;
          p_waddr   = '0;
          p_wdata   = {vy_r, vx_r};
          i_nxt     = i_r + CNTW'(1);
          state_nxt = ST_SI;
        end else begin
          state_nxt = ST_SC;
        end
      end
      ST_SC: begin
        p_we    = 1'b1;
        p_waddr = j_r[AW-1:0];
        if (v_less) begin
          p_wdata   = p_rdata;
          j_nxt     = j_r - CNTW'(1);
          state_nxt = ST_SJ;
        end else begin
          p_wdata   = {vy_r, vx_r};
          i_nxt     = i_r + CNTW'(1);
          state_nxt = ST_SI;
        end
      end
      // chain build, upper left to right, lower right to left
      ST_CR: begin
        p_raddr   = k_r[AW-1:0];
        state_nxt = ST_CP;
      end
      ST_CP: begin
        px_nxt    = prx;
        py_nxt    = pry;
        state_nxt = ST_CT;
      end
      ST_CT: begin
        state_nxt = (len_r >= CNTW'(CHAIN_MIN)) ? ST_CM1 : ST_CU;
      end
      ST_CM1: begin
        prod1_nxt = mul_p;
        state_nxt = ST_CM2;
      end
      ST_CM2: begin
        prod2_nxt = mul_p;
        state_nxt = ST_CD;
      end
      ST_CD: begin
        if (drop_mid) begin
          len_nxt = len_r - CNTW'(1);
          t1x_nxt = t2x_r;
          t1y_nxt = t2y_r;
          state_nxt = (len_r > CNTW'(CHAIN_MIN)) ? ST_CL : ST_CT;
        end else begin
          state_nxt = ST_CU;
        end
      end
      ST_CL: begin
        t2x_nxt   = crx;
        t2y_nxt   = cry;
        state_nxt = ST_CT;
      end
      ST_CU: begin
        c_we    = 1'b1;
        t2x_nxt = t1x_r;
        t2y_nxt = t1y_r;
        t1x_nxt = px_r;
        t1y_nxt = py_r;
        len_nxt = len_r + CNTW'(1);
        state_nxt = ST_CR;
        if (!lower_r) begin
          if (k_r == n_r - CNTW'(1)) begin
            nu_nxt    = len_r + CNTW'(1);
            lower_nxt = 1'b1;
            len_nxt   = '0;
          end else begin
            k_nxt = k_r + CNTW'(1);
          end
        end else begin
          if (k_r == '0) begin
            // hull is upper chain plus lower chain minus both ends
            size_nxt  = nu_r + len_r - CNTW'(1);
            e_nxt     = '0;
            state_nxt = ST_ER;
          end else begin
            k_nxt = k_r - CNTW'(1);
          end
        end
      end
      // emission, read, latch and offer each vertex in turn
      ST_ER: begin
        p_raddr   = e_r[AW-1:0];
        c_raddr   = e_caddr;
        state_nxt = ST_EW;
      end
      ST_EW: begin
        ox_nxt    = small_r ? prx : crx;
        oy_nxt    = small_r ? pry : cry;
        ofin_nxt  = (e_r == size_r - CNTW'(1));
        state_nxt = ST_EO;
      end
      ST_EO: begin
        if (out_ready) begin
          e_nxt     = e_r + CNTW'(1);
          state_nxt = ofin_r ? ST_IDLE : ST_ER;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r       <= n_nxt;
    dropped_r <= dropped_nxt;
    i_r       <= i_nxt;
    j_r       <= j_nxt;
    k_r       <= k_nxt;
    len_r     <= len_nxt;
    nu_r      <= nu_nxt;
    size_r    <= size_nxt;
    e_r       <= e_nxt;
    lower_r   <= lower_nxt;
    small_r   <= small_nxt;
    vx_r      <= vx_nxt;
    vy_r      <= vy_nxt;
    px_r      <= px_nxt;
    py_r      <= py_nxt;
    t1x_r     <= t1x_nxt;
    t1y_r     <= t1y_nxt;
    t2x_r     <= t2x_nxt;
    t2y_r     <= t2y_nxt;
    prod1_r   <= prod1_nxt;
    prod2_r   <= prod2_nxt;
    ox_r      <= ox_nxt;
    oy_r      <= oy_nxt;
    ofin_r    <= ofin_nxt;
  end

  // result word, coordinates sign extended to the port width
  assign out_valid          = (state_r == ST_EO);
  assign out_hull_x         = IO_W'(ox_r);
  assign out_hull_y         = IO_W'(oy_r);
  assign out_hull_size      = HULL_SIZE_W'(size_r);
  assign out_final_vertex   = ofin_r;
  assign out_points_dropped = dropped_r;
endmodule

`default_nettype wire

// ===== hw/rtl/chx_checker.sv =====
// ----------------------------------------------------------------------------
// chx_checker
// port level checks for the convex hull block
// ----------------------------------------------------------------------------
`default_nettype none
`include "convex_hull_2d_defines.svh"

module chx_checker (
  input wire logic                                 clk,
  input wire logic                                 rst_n,
  input wire logic                                 in_valid,
  input wire logic                                 in_ready,
  input wire logic signed [chx_pkg::IO_W-1:0]      in_point_x,
  input wire logic signed [chx_pkg::IO_W-1:0]      in_point_y,
  input wire logic                                 in_last_point,
  input wire logic                                 out_valid,
  input wire logic                                 out_ready,
  input wire logic signed [chx_pkg::IO_W-1:0]      out_hull_x,
  input wire logic signed [chx_pkg::IO_W-1:0]      out_hull_y,
  input wire logic        [chx_pkg::HULL_SIZE_W-1:0] out_hull_size,
  input wire logic                                 out_final_vertex,
  input wire logic                                 out_points_dropped
);
  import chx_pkg::*;

  logic out_stall, in_stall;
  assign out_stall = out_valid && !out_ready;
  assign in_stall  = in_valid && !in_ready;

  // loading and emitting never overlap
  `CHX_ASSERT_NOW(a_no_overlap, in_ready, !out_valid, "ready while emitting")
  // closing point starts the hull work
  `CHX_ASSERT_NEXT(a_close_busy, in_valid && in_ready && in_last_point, !in_ready,
    "ready right after closing point")
  // last vertex taken returns to loading
  `CHX_ASSERT_NEXT(a_final_ready, out_valid && out_ready && out_final_vertex, in_ready,
    "not ready after final vertex")
  // a stalled word holds
  `CHX_ASSERT_NEXT(a_out_hold, out_stall,
    out_valid && $stable(out_hull_x) && $stable(out_hull_y) && $stable(out_hull_size) && $stable(out_final_vertex) && $stable(out_points_dropped),
    "stalled result changed")
  // a waiting input word holds
  `CHX_ASSERT_NEXT(a_in_hold, in_stall,
    in_valid && $stable(in_point_x) && $stable(in_point_y) && $stable(in_last_point),
    "waiting input word changed")
endmodule

bind convex_hull_2d chx_checker u_chx_checker (.*);

`default_nettype wire
